// File: hw/rtl/swyh_pkg.sv
// Package for the streaming wyhash-style 64-bit hash block.
// Holds the hash secrets, the byte counter width and tail buffer sizes.
// No dependencies.
package swyh_pkg;

   // Width of the message byte counter; the count wraps at 2^COUNT_BITS
   localparam int COUNT_BITS = 64;

   // Bytes folded per block and index width into the tail buffer
   localparam int BLOCK_BYTES   = 16;
   localparam int TAIL_IDX_BITS = $clog2(BLOCK_BYTES);
   localparam int FILL_BITS     = TAIL_IDX_BITS + 1;

   // Hash secrets
   localparam logic [63:0] SECRET0 = 64'ha0761d6478bd642f;
   localparam logic [63:0] SECRET1 = 64'he7037ed1a0b428db;

endpackage

// File: hw/rtl/streaming_wyhash64_top.sv
// Streaming wyhash-style 64-bit hash: top level with sequencer, tail buffer and
// a shared 32x32 multiplier that builds each 64x64 -> 128-bit product.
// Depends on swyh_pkg.

// A request carries one message byte (req_has_byte = 1) or none, and req_last
// ends the message; the 64-bit hash then appears on rsp_hash_value. A byte
// that goes into a tail buffer with room leaves the sequencer idle, so bytes
// stream in at one per clock while the buffer has room. The 17th, 33rd and
// every later 16th byte of a message first folds the 16 held bytes into the
// seed: that request loads the operands and then runs one 64x64 product. A
// request with req_last reads the tail words out of the buffer one byte a
// cycle, runs two 64x64 products and rebuilds the initial seed; the second
// product waits as long as an earlier hash is still stalled. After reset the
// block computes the initial seed before it takes its first request. Every
// product goes through the one 32x32 multiplier, four partial products per
// 64x64 multiply. A finished hash waits in an output register, so the next
// message can start while the hash is still stalled.
module streaming_wyhash64_top
   import swyh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_value,
   input  logic        req_has_byte,
   input  logic        req_last,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_hash_value
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_GATHER,
      ST_MUL
   } state_type;

   // What the multiply in flight is for
   typedef enum logic [1:0] {
      PH_INIT,
      PH_ABSORB,
      PH_FIN1,
      PH_FIN2
   } phase_type;

   localparam logic [2:0] MUL_DONE = 3'd4;
   localparam logic [TAIL_IDX_BITS-1:0] GATHER_LAST = '1;
   localparam logic [FILL_BITS-1:0] FILL_FULL = FILL_BITS'(BLOCK_BYTES);

   state_type                state_ff,     state_in;
   phase_type                phase_ff,     phase_in;
   logic [2:0]               mul_step_ff,  mul_step_in;
   logic [63:0]              op_a_ff,      op_a_in;
   logic [63:0]              op_b_ff,      op_b_in;
   logic [63:0]              prod_ff,      prod_in;
   logic [127:0]             acc_ff,       acc_in;
   logic [63:0]              seed_ff,      seed_in;
   logic [COUNT_BITS-1:0]    count_ff,     count_in;
   logic [FILL_BITS-1:0]     fill_ff,      fill_in;
   logic [TAIL_IDX_BITS-1:0] gat_ff,       gat_in;
   logic [127:0]             ab_ff,        ab_in;
   logic [7:0]               pend_byte_ff, pend_byte_in;
   logic                     pend_last_ff, pend_last_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [63:0]              rsp_hash_ff,  rsp_hash_in;

   logic [7:0] tail_ff [BLOCK_BYTES];
   logic                     tail_we;
   logic [TAIL_IDX_BITS-1:0] tail_wa;
   logic [7:0]               tail_wd;

   logic                     req_accept;
   logic [31:0]              mul_a;
   logic [31:0]              mul_b;
   logic [127:0]             prod_sh;
   logic [127:0]             acc_sum;
   logic [63:0]              mix_out;
   logic [63:0]              blk_lo;
   logic [63:0]              blk_hi;
   logic [FILL_BITS-1:0]     off;
   logic [FILL_BITS-1:0]     gat_base;
   logic [FILL_BITS-1:0]     gat_addr;
   logic                     gat_zero;
   logic [7:0]               gat_byte;
   logic [127:0]             ab_next;
   logic                     out_free;

   assign req_stall      = (state_ff != ST_IDLE);
   assign req_accept     = req_valid && (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;
   assign out_free       = !rsp_valid_ff || !rsp_stall;

   // Pick the 32-bit halves for this partial product
   always_comb begin
      mul_a = ((mul_step_ff == 3'd2) || (mul_step_ff == 3'd3)) ? op_a_ff[63:32]
                                                               : op_a_ff[31:0];
      mul_b = ((mul_step_ff == 3'd1) || (mul_step_ff == 3'd3)) ? op_b_ff[63:32]
                                                               : op_b_ff[31:0];
   end

   // Align the registered partial product issued in the previous step
   always_comb begin
      case (mul_step_ff)
         3'd1:     prod_sh = {64'd0, prod_ff};
         3'd2,
         3'd3:     prod_sh = {32'd0, prod_ff, 32'd0};
         3'd4:     prod_sh = {prod_ff, 64'd0};
         default:  prod_sh = '0;
      endcase
   end

   assign acc_sum = acc_ff + prod_sh;
   assign mix_out = acc_sum[63:0] ^ acc_sum[127:64];

   // Held block as two little-endian words
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         blk_lo[i*8 +: 8] = tail_ff[i];
         blk_hi[i*8 +: 8] = tail_ff[i+8];
      end
   end

   // Tail word read-out: one byte a cycle into ab (a low, a high, b low, b high)
   always_comb begin
      off      = {1'b0, fill_ff[FILL_BITS-1:3], 2'b00};
      gat_zero = 1'b0;
      gat_base = '0;
      if (fill_ff >= FILL_BITS'(4)) begin
         case (gat_ff[3:2])
            2'd0:    gat_base = off;
            2'd1:    gat_base = '0;
            2'd2:    gat_base = fill_ff - FILL_BITS'(4) - off;
            2'd3:    gat_base = fill_ff - FILL_BITS'(4);
            default: gat_base = '0;
         endcase
         gat_addr = gat_base + FILL_BITS'(gat_ff[1:0]);
      end else begin
         // short message: bytes n-1, n/2 and 0 form the low 24 bits of a
         case (gat_ff)
            4'd0:    gat_addr = fill_ff - FILL_BITS'(1);
            4'd1:    gat_addr = fill_ff >> 1;
            4'd2:    gat_addr = '0;
            default: gat_addr = '0;
         endcase
         gat_zero = (fill_ff == '0) || (gat_ff > 4'd2);
      end
      gat_byte = gat_zero ? 8'd0 : tail_ff[gat_addr[TAIL_IDX_BITS-1:0]];
      ab_next  = {gat_byte, ab_ff[127:8]};
   end

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      mul_step_in  = mul_step_ff;
      op_a_in      = op_a_ff;
      op_b_in      = op_b_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      seed_in      = seed_ff;
      count_in     = count_ff;
      fill_in      = fill_ff;
      gat_in       = gat_ff;
      ab_in        = ab_ff;
      pend_byte_in = pend_byte_ff;
      pend_last_in = pend_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_hash_in  = rsp_hash_ff;
      tail_we      = 1'b0;
      tail_wa      = fill_ff[TAIL_IDX_BITS-1:0];
      tail_wd      = req_byte_value;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_has_byte) begin
                  count_in = count_ff + COUNT_BITS'(1);
                  if (fill_ff == FILL_FULL) begin
                     // fold the held block, keep the new byte pending
                     pend_byte_in = req_byte_value;
                     pend_last_in = req_last;
                     op_a_in      = blk_lo ^ SECRET1;
                     op_b_in      = blk_hi ^ seed_ff;
                     phase_in     = PH_ABSORB;
                     mul_step_in  = '0;
                     state_in     = ST_MUL;
                  end else begin
                     tail_we = 1'b1;
                     fill_in = fill_ff + FILL_BITS'(1);
                     if (req_last) begin
                        gat_in   = '0;
                        state_in = ST_GATHER;
                     end
                  end
               end else if (req_last) begin
                  gat_in   = '0;
                  state_in = ST_GATHER;
               end
            end
         end

         ST_GATHER: begin
            ab_in  = ab_next;
            gat_in = gat_ff + TAIL_IDX_BITS'(1);
            if (gat_ff == GATHER_LAST) begin
               op_a_in     = ab_next[63:0] ^ SECRET1;
               op_b_in     = ab_next[127:64] ^ seed_ff;
               phase_in    = PH_FIN1;
               mul_step_in = '0;
               state_in    = ST_MUL;
            end
         end

         ST_MUL: begin
            if (mul_step_ff != MUL_DONE) begin
               // issue one partial product, accumulate the previous one
               prod_in     = 64'(mul_a) * 64'(mul_b);
               acc_in      = (mul_step_ff == '0) ? '0 : acc_sum;
               mul_step_in = mul_step_ff + 3'd1;
            end else begin
               case (phase_ff)
                  PH_INIT: begin
                     seed_in  = mix_out;
                     state_in = ST_IDLE;
                  end
                  PH_ABSORB: begin
                     seed_in = mix_out;
                     tail_we = 1'b1;
                     tail_wa = '0;
                     tail_wd = pend_byte_ff;
                     fill_in = FILL_BITS'(1);
                     gat_in  = '0;
                     state_in = pend_last_ff ? ST_GATHER : ST_IDLE;
                  end
                  PH_FIN1: begin
                     op_a_in     = acc_sum[63:0] ^ SECRET0 ^ 64'(count_ff);
                     op_b_in     = acc_sum[127:64] ^ SECRET1;
                     phase_in    = PH_FIN2;
                     mul_step_in = '0;
                  end
                  PH_FIN2: begin
                     // hold the finished product until the output slot frees
                     if (out_free) begin
                        rsp_valid_in = 1'b1;
                        rsp_hash_in  = mix_out;
                        count_in     = '0;
                        fill_in      = '0;
                        op_a_in      = SECRET0;
                        op_b_in      = SECRET1;
                        phase_in     = PH_INIT;
                        mul_step_in  = '0;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_MUL;
         phase_ff     <= PH_INIT;
         mul_step_ff  <= '0;
         op_a_ff      <= SECRET0;
         op_b_ff      <= SECRET1;
         count_ff     <= '0;
         fill_ff      <= '0;
         gat_ff       <= '0;
         pend_last_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         mul_step_ff  <= mul_step_in;
         op_a_ff      <= op_a_in;
         op_b_ff      <= op_b_in;
         count_ff     <= count_in;
         fill_ff      <= fill_in;
         gat_ff       <= gat_in;
         pend_last_ff <= pend_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      seed_ff      <= seed_in;
      ab_ff        <= ab_in;
      pend_byte_ff <= pend_byte_in;
      rsp_hash_ff  <= rsp_hash_in;
   end

   // Tail buffer write
   always_ff @(posedge clock) begin
      if (tail_we) begin
         tail_ff[tail_wa] <= tail_wd;
      end
   end

endmodule

// File: verif/swyh_hash_checker.sv
`timescale 1ns / 1ps
// Checker for streaming_wyhash64_top. It follows each accepted request with its own
// hash model and compares every response with the oldest hash still expected.
// Depends on swyh_pkg for the secrets, the count width and the block size.
module swyh_hash_checker
   import swyh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_byte_value,
   input  logic        req_has_byte,
   input  logic        req_last,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [63:0] rsp_hash_value,
   output int          error_count,
   output int          pending_hashes
);

   // Model state of the message in progress
   logic [63:0]           seed_q;
   logic [COUNT_BITS-1:0] count_q;
   logic [7:0]            held [BLOCK_BYTES];
   int unsigned           held_n;
   logic [63:0]           expected_hashes [$];

   // Fold a 64x64 product into 64 bits: low half xor high half
   function automatic logic [63:0] fold_mix(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[63:0] ^ p[127:64];
   endfunction

   // Little-endian 32-bit word from the held bytes
   function automatic logic [31:0] held_le32(input int unsigned pos);
      logic [31:0] w;
      int          i;
      for (i = 0; i < 4; i++) begin
         w[8*i +: 8] = held[(pos + i) % BLOCK_BYTES];
      end
      return w;
   endfunction

   // Start a fresh message: initial seed, empty count and tail
   function automatic void restart_message();
      seed_q  = fold_mix(SECRET0, SECRET1);
      count_q = '0;
      held_n  = 0;
   endfunction

   // Hash of the message so far from the tail words, the seed and the count
   function automatic logic [63:0] message_hash();
      int unsigned  n;
      int unsigned  off;
      logic [63:0]  a;
      logic [63:0]  b;
      logic [127:0] p;
      n = held_n;
      if (n >= 4) begin
         off = (n >> 3) << 2;
         a   = {held_le32(0), held_le32(off)};
         b   = {held_le32(n - 4), held_le32(n - 4 - off)};
      end else if (n != 0) begin
         a = {40'd0, held[0], held[n >> 1], held[n - 1]};
         b = 64'd0;
      end else begin
         a = 64'd0;
         b = 64'd0;
      end
      p = {64'd0, a ^ SECRET1} * {64'd0, b ^ seed_q};
      return fold_mix(p[63:0] ^ SECRET0 ^ 64'(count_q), p[127:64] ^ SECRET1);
   endfunction

   always @(posedge clock) begin : track
      logic [63:0] want;
      if (reset) begin
         restart_message();
         expected_hashes.delete();
         error_count <= 0;
      end else begin
         // Compare a response before taking this edge's request
         if (rsp_valid && !rsp_stall) begin
            if (expected_hashes.size() == 0) begin
               $error("hash_value: expected none, actual %h", rsp_hash_value);
               error_count <= error_count + 1;
            end else begin
               want = expected_hashes.pop_front();
               if (rsp_hash_value !== want) begin
                  $error("hash_value: expected %h, actual %h", want, rsp_hash_value);
                  error_count <= error_count + 1;
               end
            end
         end
         // Advance the model on an accepted request
         if (req_valid && !req_stall) begin
            if (req_has_byte) begin
               // Absorb a full tail before storing the next byte
               if (held_n == BLOCK_BYTES) begin
                  seed_q = fold_mix({held_le32(4), held_le32(0)} ^ SECRET1,
                                    {held_le32(12), held_le32(8)} ^ seed_q);
                  held_n = 0;
               end
               held[held_n] = req_byte_value;
               held_n++;
               count_q = count_q + 1'b1;
            end
            if (req_last) begin
               expected_hashes.push_back(message_hash());
               restart_message();
            end
         end
      end
      pending_hashes <= expected_hashes.size();
   end

endmodule

// File: verif/streaming_wyhash64_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for streaming_wyhash64_top: drives directed and random byte
// messages with bursty requests and a patterned response stall.
// Depends on swyh_pkg, streaming_wyhash64_top and swyh_hash_checker.
module streaming_wyhash64_top_tb;
   import swyh_pkg::*;

   localparam int IDLE_LIMIT  = 4000;
   localparam int TARGET_REQS = 500;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_byte_value = 8'd0;
   logic        req_has_byte = 1'b0;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_hash_value;

   int error_count;
   int pending_hashes;
   int burst_left = 0;
   int sent_reqs = 0;
   int idle_cycles = 0;
   int stall_mode = 0;
   int stall_left = 0;
   int stall_tick = 0;

   always #5 clock = ~clock;

   streaming_wyhash64_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_byte_value (req_byte_value),
      .req_has_byte   (req_has_byte),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value)
   );

   swyh_hash_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_byte_value (req_byte_value),
      .req_has_byte   (req_has_byte),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value),
      .error_count    (error_count),
      .pending_hashes (pending_hashes)
   );

   // Response stall: switch between free, random, heavy and periodic patterns
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 200);
      end else begin
         stall_left--;
      end
      stall_tick++;
      case (stall_mode)
         0: begin
            rsp_stall <= 1'b0;
         end
         1: begin
            rsp_stall <= 1'($urandom_range(0, 1));
         end
         2: begin
            rsp_stall <= ($urandom_range(0, 9) < 8);
         end
         default: begin
            rsp_stall <= ((stall_tick % 7) < 3);
         end
      endcase
   end

   // Watchdog: end the run after too long without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("** streaming_wyhash64_top: FAILED **");
         $finish;
      end
   end

   // Present one request and hold it until accepted; open a gap between bursts
   task automatic send_request(input logic [7:0] value, input logic has_byte,
                               input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_byte_value <= value;
      req_has_byte   <= has_byte;
      req_last       <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drop valid and hold until every expected hash has been delivered
   task automatic drain_hashes();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_hashes != 0) @(posedge clock);
   endtask

   // Random message of len bytes, closed on the last byte or by a bare end marker
   task automatic send_message(input int len, input bit bare_end);
      int i;
      for (i = 0; i < len; i++) begin
         if ($urandom_range(0, 11) == 0) begin
            send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         end
         send_request(8'($urandom_range(0, 255)), 1'b1, !bare_end && (i == len - 1));
         sent_reqs++;
      end
      if (bare_end) begin
         send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
         sent_reqs++;
      end
   endtask

   initial begin : stimulus
      int  i;
      int  pick;
      int  len;
      bit  paused;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Empty message, idle request, single byte with last
      send_request(8'hA5, 1'b0, 1'b1);
      send_request(8'hFF, 1'b0, 1'b0);
      send_request(8'hFF, 1'b1, 1'b1);
      // Three-byte tail with byte extremes
      send_request(8'h00, 1'b1, 1'b0);
      send_request(8'hFF, 1'b1, 1'b0);
      send_request(8'h80, 1'b1, 1'b1);
      // 17 bytes force one block fold, then a bare end marker
      for (i = 0; i < 17; i++) begin
         send_request((i == 0) ? 8'h00 : (i == 16) ? 8'hFF : 8'(i * 37 + 11), 1'b1, 1'b0);
      end
      send_request(8'h5A, 1'b0, 1'b1);
      drain_hashes();

      // Random messages, mostly short, a few spanning several blocks
      paused = 1'b0;
      while (sent_reqs < TARGET_REQS) begin
         pick = $urandom_range(0, 29);
         if (pick == 0) begin
            len = $urandom_range(49, 100);
         end else if (pick < 6) begin
            len = $urandom_range(17, 48);
         end else begin
            len = $urandom_range(0, 16);
         end
         send_message(len, (len == 0) || ($urandom_range(0, 2) == 0));
         if (!paused && sent_reqs >= TARGET_REQS / 2) begin
            drain_hashes();
            paused = 1'b1;
         end
      end

      // Let the last hash arrive, then give the verdict
      drain_hashes();
      repeat (64) @(posedge clock);
      if (error_count == 0 && pending_hashes == 0) begin
         $display("** streaming_wyhash64_top: PASSED **");
      end else begin
         $display("** streaming_wyhash64_top: FAILED **");
      end
      $finish;
   end

endmodule
